@@ rtl/phbqm_pkg.sv @@
// ----------------------------------------------------------------------------
// phbqm_pkg
// Types, register codes and small helper functions shared by the per-host
// byte quota meter.
// ----------------------------------------------------------------------------
package phbqm_pkg;

  typedef struct packed {
    logic        action;
    logic [30:0] now_local_seconds;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] packet_length;
    logic [31:0] query_addr;
  } phbqm_in_t;

  typedef struct packed {
    logic        matched;
    logic        found;
    logic [63:0] byte_count;
    logic        insert_dropped;
  } phbqm_out_t;

  typedef struct packed {
    logic [2:0]  count_mode;
    logic [31:0] subnet_base;
    logic [31:0] subnet_mask;
    logic [63:0] byte_cutoff;
    logic [1:0]  compare_mode;
    logic [2:0]  reset_period;
    logic [21:0] reset_offset;
  } phbqm_cfg_t;

  // One classified word on its way from the front end to the engine.
  typedef struct packed {
    logic        is_query;
    logic        is_comb;
    logic        k0_en;
    logic        k1_en;
    logic [30:0] now;
    logic [31:0] key0;
    logic [31:0] key1;
    logic [15:0] len;
  } phbqm_job_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CHECK, ST_CLEAR, ST_DIV, ST_WEEK, ST_FIXED, ST_YEAR,
    ST_MONTH, ST_MONTH2, ST_MONTH3, ST_KEY, ST_SRD, ST_SCMP, ST_MISS,
    ST_BRD, ST_BUPD, ST_FINISH
  } phbqm_state_t;

  localparam logic [2:0] REG_COUNT_MODE   = 3'd0;
  localparam logic [2:0] REG_SUBNET_BASE  = 3'd1;
  localparam logic [2:0] REG_SUBNET_MASK  = 3'd2;
  localparam logic [2:0] REG_BYTE_CUTOFF  = 3'd3;
  localparam logic [2:0] REG_COMPARE_MODE = 3'd4;
  localparam logic [2:0] REG_RESET_PERIOD = 3'd5;
  localparam logic [2:0] REG_RESET_OFFSET = 3'd6;

  localparam logic [2:0] MODE_COMBINED = 3'd0;
  localparam logic [2:0] MODE_SRC      = 3'd1;
  localparam logic [2:0] MODE_DST      = 3'd2;
  localparam logic [2:0] MODE_LOCAL    = 3'd3;
  localparam logic [2:0] MODE_REMOTE   = 3'd4;

  localparam logic [1:0] CMP_ABOVE = 2'd1;
  localparam logic [1:0] CMP_BELOW = 2'd2;

  localparam logic [2:0] PER_MINUTE = 3'd1;
  localparam logic [2:0] PER_HOUR   = 3'd2;
  localparam logic [2:0] PER_DAY    = 3'd3;
  localparam logic [2:0] PER_WEEK   = 3'd4;
  localparam logic [2:0] PER_MONTH  = 3'd5;

  localparam logic        ACT_QUERY = 1'b1;

  localparam logic [19:0] SECS_MIN  = 20'd60;
  localparam logic [19:0] SECS_HOUR = 20'd3600;
  localparam logic [19:0] SECS_DAY  = 20'd86400;
  localparam logic [19:0] SECS_WEEK = 20'd604800;

  // Reciprocals scaled by 2^32 and rounded down, for division by constants.
  localparam logic [31:0] RECIP_MIN  = 32'd71582788;
  localparam logic [31:0] RECIP_HOUR = 32'd1193046;
  localparam logic [31:0] RECIP_DAY  = 32'd49710;
  localparam logic [31:0] RECIP_WEEK = 32'd613566756;

  localparam logic [11:0] EPOCH_YEAR   = 12'd1970;
  localparam logic [11:0] YEAR_CAP     = 12'd2100;
  localparam logic [1:0]  EPOCH_MOD4   = 2'd2;
  localparam logic [6:0]  EPOCH_MOD100 = 7'd70;
  localparam logic [8:0]  EPOCH_MOD400 = 9'd370;
  localparam logic [3:0]  LAST_MONTH   = 4'd11;
  localparam logic [30:0] WEEKDAY_BIAS = 31'd4;
  localparam logic [16:0] DAYS_WEEK    = 17'd7;

  function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
    logic [8:0] d;
    case (m)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    if (leap && m >= 4'd2) begin
      d = d + 9'd1;
    end
    return d;
  endfunction

  function automatic logic [19:0] period_secs(input logic [2:0] p);
    case (p)
      PER_MINUTE: return SECS_MIN;
      PER_HOUR:   return SECS_HOUR;
      PER_DAY:    return SECS_DAY;
      PER_WEEK:   return SECS_WEEK;
      default:    return SECS_DAY;
    endcase
  endfunction

  function automatic logic [16:0] period_divisor(input logic [2:0] p);
    case (p)
      PER_MINUTE: return 17'(SECS_MIN);
      PER_HOUR:   return 17'(SECS_HOUR);
      default:    return 17'(SECS_DAY);
    endcase
  endfunction

  function automatic logic hits(input logic [63:0] v, input phbqm_cfg_t c);
    case (c.compare_mode)
      CMP_ABOVE: return v > c.byte_cutoff;
      CMP_BELOW: return v < c.byte_cutoff;
      default:   return 1'b0;
    endcase
  endfunction

endpackage

@@ rtl/phbqm_front.sv @@
// ----------------------------------------------------------------------------
// phbqm_front
// Accepts input words and works out which host keys the engine must count.
// ----------------------------------------------------------------------------
module phbqm_front (
  input  phbqm_pkg::phbqm_cfg_t cfg,
  input  logic                  in_valid,
  input  phbqm_pkg::phbqm_in_t  in_data,
  output logic                  in_stall,
  input  logic                  q_full,
  output logic                  q_push,
  output phbqm_pkg::phbqm_job_t q_data
);
  import phbqm_pkg::*;

  logic src_local;
  logic dst_local;
  logic want_local;
  logic [31:0] key_src;
  logic [31:0] key_dst;

  assign in_stall   = q_full;
  assign q_push     = in_valid && !q_full;
  assign src_local  = (cfg.subnet_mask & in_data.src_addr) == cfg.subnet_base;
  assign dst_local  = (cfg.subnet_mask & in_data.dst_addr) == cfg.subnet_base;
  assign want_local = cfg.count_mode == MODE_LOCAL;
  assign key_src    = (src_local == want_local) ? in_data.src_addr : 32'd0;
  assign key_dst    = (dst_local == want_local) ? in_data.dst_addr : 32'd0;

  always_comb begin
    q_data          = '0;
    q_data.now      = in_data.now_local_seconds;
    q_data.len      = in_data.packet_length;
    if (in_data.action == ACT_QUERY) begin
      q_data.is_query = 1'b1;
      q_data.key0     = in_data.query_addr;
      q_data.k0_en    = 1'b1;
    end else begin
      case (cfg.count_mode)
        MODE_COMBINED: begin
          q_data.is_comb = 1'b1;
          q_data.k0_en   = 1'b1;
        end
        MODE_SRC: begin
          q_data.key0  = in_data.src_addr;
          q_data.k0_en = in_data.src_addr != 32'd0;
        end
        MODE_DST: begin
          q_data.key0  = in_data.dst_addr;
          q_data.k0_en = in_data.dst_addr != 32'd0;
        end
        MODE_LOCAL, MODE_REMOTE: begin
          q_data.key0  = key_src;
          q_data.k0_en = key_src != 32'd0;
          q_data.key1  = key_dst;
          q_data.k1_en = key_dst != 32'd0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ rtl/phbqm_fifo.sv @@
// ----------------------------------------------------------------------------
// phbqm_fifo
// Two-word queue between the front end and the engine.
// ----------------------------------------------------------------------------
module phbqm_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  phbqm_pkg::phbqm_job_t push_data,
  output logic                  full,
  input  logic                  pop,
  output phbqm_pkg::phbqm_job_t pop_data,
  output logic                  empty
);
  import phbqm_pkg::*;

  phbqm_job_t slots_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;

  assign full     = cnt_r == 2'd2;
  assign empty    = cnt_r == 2'd0;
  assign pop_data = slots_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ rtl/phbqm_div.sv @@
// ----------------------------------------------------------------------------
// phbqm_div
// Divider for the fixed time divisors: reciprocal multiply, then quotient
// estimate and back-multiply, then one compare-and-subtract correction.
// ----------------------------------------------------------------------------
module phbqm_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [30:0] dividend,
  input  logic [16:0] divisor,
  output logic        busy,
  output logic [30:0] quot,
  output logic [16:0] rem
);
  import phbqm_pkg::*;

  logic        busy_r;
  logic [1:0]  ph_r;
  logic [30:0] x_r;
  logic [16:0] d_r;
  logic [31:0] m_r;
  logic [62:0] prod_r;
  logic [30:0] qe_r;
  logic [30:0] qd_r;
  logic [30:0] q_r;
  logic [16:0] rem_r;
  logic [31:0] recip;
  logic [30:0] diff;
  logic        take;

  always_comb begin
    case (divisor)
      17'(SECS_MIN):  recip = RECIP_MIN;
      17'(SECS_HOUR): recip = RECIP_HOUR;
      DAYS_WEEK:      recip = RECIP_WEEK;
      default:        recip = RECIP_DAY;
    endcase
  end

  // The estimate is the true quotient or one below it.
  assign diff  = x_r - qd_r;
  assign take  = diff >= 31'(d_r);
  assign busy  = busy_r;
  assign quot  = q_r;
  assign rem   = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ph_r   <= 2'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      ph_r   <= 2'd2;
    end else if (busy_r) begin
      ph_r <= ph_r - 2'd1;
      if (ph_r == 2'd0) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= dividend;
      d_r <= divisor;
      m_r <= recip;
    end else if (busy_r) begin
      case (ph_r)
        2'd2: begin
          prod_r <= 63'(x_r) * 63'(m_r);
        end
        2'd1: begin
          qe_r <= prod_r[62:32];
          qd_r <= prod_r[62:32] * 31'(d_r);
        end
        default: begin
          q_r   <= take ? qe_r + 31'd1 : qe_r;
          rem_r <= take ? 17'(diff - 31'(d_r)) : diff[16:0];
        end
      endcase
    end
  end

endmodule

@@ rtl/phbqm_back.sv @@
// ----------------------------------------------------------------------------
// phbqm_back
// Engine: period reset, table search and insert, counter update, compare.
// ----------------------------------------------------------------------------
module phbqm_back #(
  parameter int TABLE_ENTRIES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  phbqm_pkg::phbqm_cfg_t cfg,
  input  logic                  q_empty,
  input  phbqm_pkg::phbqm_job_t q_data,
  output logic                  q_pop,
  output logic                  out_valid,
  output phbqm_pkg::phbqm_out_t out_data,
  input  logic                  out_stall
);
  import phbqm_pkg::*;

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  phbqm_state_t state_r, state_nxt;
  phbqm_job_t   job_r, job_nxt;
  logic [63:0]  total_r, total_nxt;
  logic [31:0]  deadline_r, deadline_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic         ksel_r, ksel_nxt;
  logic [IW-1:0] slot_r, slot_nxt;
  logic [IW-1:0] slot0_r, slot0_nxt;
  logic [IW-1:0] slot1_r, slot1_nxt;
  logic         s0_r, s0_nxt, s1_r, s1_nxt;
  logic [63:0]  v0_r, v0_nxt, v1_r, v1_nxt;
  logic         dropped_r, dropped_nxt;
  logic         found_r, found_nxt;
  logic [63:0]  count_r, count_nxt;
  logic [30:0]  q_r, q_nxt;
  logic [33:0]  base_r, base_nxt;
  logic [11:0]  year_r, year_nxt;
  logic [1:0]   y4_r, y4_nxt;
  logic [6:0]   y100_r, y100_nxt;
  logic [8:0]   y400_r, y400_nxt;
  logic [15:0]  start_r, start_nxt;
  logic [33:0]  alt_r, alt_nxt;
  logic [15:0]  nday_r, nday_nxt;
  logic         out_valid_r, out_valid_nxt;
  phbqm_out_t   out_data_r, out_data_nxt;

  logic [31:0] key_mem [TABLE_ENTRIES];
  logic [63:0] byte_mem [TABLE_ENTRIES];
  logic [31:0] key_rd_r;
  logic [63:0] byte_rd_r;
  logic        key_we, byte_we;
  logic [IW-1:0] key_waddr, byte_waddr;
  logic [31:0] key_wdata;
  logic [63:0] byte_wdata;

  logic        div_start, div_busy;
  logic [30:0] div_dividend, div_quot;
  logic [16:0] div_divisor, div_rem;

  logic [31:0] cur_key;
  logic        cur_en, due, out_free, key_hit, last_idx, table_full, fill_zero;
  logic [CW-1:0] idx_inc;
  logic [33:0] now34, pp34, off34, late, early, fix_res;
  logic        leap, year_stop;
  logic [8:0]  ylen;
  logic [15:0] start_plus, yday;
  logic [3:0]  m_sel;
  logic [8:0]  ms_cur, ms_next;
  logic [63:0] len64, total_eff, v0_cmp, upd_val;
  logic        matched;

  phbqm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  assign cur_key    = ksel_r ? job_r.key1 : job_r.key0;
  assign cur_en     = ksel_r ? job_r.k1_en : job_r.k0_en;
  assign due        = cfg.reset_period >= PER_MINUTE && cfg.reset_period <= PER_MONTH &&
                      deadline_r < {1'b0, job_r.now};
  assign out_free   = !out_valid_r || !out_stall;
  assign key_hit    = key_rd_r == cur_key;
  assign idx_inc    = CW'(idx_r + CW'(1));
  assign last_idx   = idx_inc == fill_r;
  assign table_full = fill_r == CW'(TABLE_ENTRIES);
  assign fill_zero  = fill_r == CW'(0);

  // Boundary plus offset, stepping back one period when that still lies ahead.
  assign now34   = 34'(job_r.now);
  assign pp34    = 34'(period_secs(cfg.reset_period));
  assign off34   = 34'(cfg.reset_offset);
  assign late    = base_r + off34;
  assign early   = late - pp34;
  assign fix_res = (off34 == 34'd0) ? base_r :
                   ((late > pp34 && early > now34) ? early : late);

  assign leap       = (y4_r == 2'd0) && ((y100_r != 7'd0) || (y400_r == 9'd0));
  assign ylen       = leap ? 9'd366 : 9'd365;
  assign start_plus = start_r + 16'(ylen);
  assign year_stop  = (start_plus > 16'(q_r)) || (year_r >= YEAR_CAP);
  assign yday       = 16'(q_r) - start_r;

  always_comb begin
    m_sel = 4'd0;
    for (int m = 1; m < 12; m++) begin
      if (16'(month_start(4'(m), leap)) <= yday) begin
        m_sel = 4'(m);
      end
    end
  end

  assign ms_cur  = month_start(m_sel, leap);
  assign ms_next = (m_sel == LAST_MONTH) ? ylen : month_start(4'(m_sel + 4'd1), leap);

  assign len64     = 64'(job_r.len);
  assign total_eff = (job_r.is_comb && !job_r.is_query) ? total_r + len64 : total_r;
  assign upd_val   = byte_rd_r + len64;
  // When both keys land in one entry, the first key sees the final count too.
  assign v0_cmp    = (s1_r && slot1_r == slot0_r) ? v1_r : v0_r;
  assign matched   = !job_r.is_query &&
                     (hits(total_eff, cfg) || (s0_r && hits(v0_cmp, cfg)) ||
                      (s1_r && hits(v1_r, cfg)));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (!q_empty) state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (!due) begin
          state_nxt = ST_KEY;
        end else if (fill_zero) begin
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_CLEAR;
        end
      end
      ST_CLEAR:  if (last_idx) state_nxt = ST_DIV;
      ST_DIV: begin
        if (!div_busy) begin
          case (cfg.reset_period)
            PER_WEEK:  state_nxt = ST_WEEK;
            PER_MONTH: state_nxt = ST_YEAR;
            default:   state_nxt = ST_FIXED;
          endcase
        end
      end
      ST_WEEK:   if (!div_busy) state_nxt = ST_FIXED;
      ST_FIXED:  state_nxt = ST_KEY;
      ST_YEAR:   if (year_stop) state_nxt = ST_MONTH;
      ST_MONTH:  state_nxt = ST_MONTH2;
      ST_MONTH2: state_nxt = (alt_r > now34) ? ST_KEY : ST_MONTH3;
      ST_MONTH3: state_nxt = ST_KEY;
      ST_KEY: begin
        if (cur_en) begin
          state_nxt = fill_zero ? ST_MISS : ST_SRD;
        end else if (ksel_r || job_r.is_query) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_SRD:    state_nxt = ST_SCMP;
      ST_SCMP: begin
        if (key_hit) begin
          state_nxt = ST_BRD;
        end else if (last_idx) begin
          state_nxt = ST_MISS;
        end else begin
          state_nxt = ST_SRD;
        end
      end
      ST_MISS: begin
        if (job_r.is_query || ksel_r) begin
          state_nxt = ST_FINISH;
        end else begin
          state_nxt = ST_KEY;
        end
      end
      ST_BRD:    state_nxt = ST_BUPD;
      ST_BUPD: begin
        if (job_r.is_query || ksel_r) begin
          state_nxt = ST_FINISH;
        end else begin
          state_nxt = ST_KEY;
        end
      end
      ST_FINISH: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    job_nxt      = job_r;
    total_nxt    = total_r;
    deadline_nxt = deadline_r;
    fill_nxt     = fill_r;
    idx_nxt      = idx_r;
    ksel_nxt     = ksel_r;
    slot_nxt     = slot_r;
    slot0_nxt    = slot0_r;
    slot1_nxt    = slot1_r;
    s0_nxt       = s0_r;
    s1_nxt       = s1_r;
    v0_nxt       = v0_r;
    v1_nxt       = v1_r;
    dropped_nxt  = dropped_r;
    found_nxt    = found_r;
    count_nxt    = count_r;
    q_nxt        = q_r;
    base_nxt     = base_r;
    year_nxt     = year_r;
    y4_nxt       = y4_r;
    y100_nxt     = y100_r;
    y400_nxt     = y400_r;
    start_nxt    = start_r;
    alt_nxt      = alt_r;
    nday_nxt     = nday_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    q_pop        = 1'b0;
    div_start    = 1'b0;
    div_dividend = job_r.now;
    div_divisor  = period_divisor(cfg.reset_period);
    key_we       = 1'b0;
    key_waddr    = fill_r[IW-1:0];
    key_wdata    = cur_key;
    byte_we      = 1'b0;
    byte_waddr   = fill_r[IW-1:0];
    byte_wdata   = len64;

    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop       = 1'b1;
          job_nxt     = q_data;
          ksel_nxt    = 1'b0;
          s0_nxt      = 1'b0;
          s1_nxt      = 1'b0;
          dropped_nxt = 1'b0;
          found_nxt   = 1'b0;
          count_nxt   = 64'd0;
        end
      end
      ST_CHECK: begin
        idx_nxt = CW'(0);
        if (due) begin
          total_nxt = 64'd0;
          div_start = 1'b1;
        end
      end
      ST_CLEAR: begin
        byte_we    = 1'b1;
        byte_waddr = idx_r[IW-1:0];
        byte_wdata = 64'd0;
        idx_nxt    = idx_inc;
      end
      ST_DIV: begin
        if (!div_busy) begin
          q_nxt        = div_quot;
          base_nxt     = 34'((34'(div_quot) + 34'd1) * pp34);
          // Weekday of the current day, weeks starting on Sunday.
          div_dividend = div_quot + WEEKDAY_BIAS;
          div_divisor  = DAYS_WEEK;
          div_start    = cfg.reset_period == PER_WEEK;
          start_nxt    = 16'd0;
          year_nxt     = EPOCH_YEAR;
          y4_nxt       = EPOCH_MOD4;
          y100_nxt     = EPOCH_MOD100;
          y400_nxt     = EPOCH_MOD400;
        end
      end
      ST_WEEK: begin
        if (!div_busy) begin
          base_nxt = 34'((34'(q_r) + 34'd7 - 34'(div_rem)) * 34'(SECS_DAY));
        end
      end
      ST_FIXED: begin
        deadline_nxt = fix_res[31:0];
      end
      ST_YEAR: begin
        if (!year_stop) begin
          start_nxt = start_plus;
          year_nxt  = year_r + 12'd1;
          y4_nxt    = y4_r + 2'd1;
          y100_nxt  = (y100_r == 7'd99) ? 7'd0 : y100_r + 7'd1;
          y400_nxt  = (y400_r == 9'd399) ? 9'd0 : y400_r + 9'd1;
        end
      end
      ST_MONTH: begin
        alt_nxt  = 34'(34'(start_r + 16'(ms_cur)) * 34'(SECS_DAY)) + off34;
        nday_nxt = start_r + 16'(ms_next);
      end
      ST_MONTH2: begin
        if (alt_r > now34) begin
          deadline_nxt = alt_r[31:0];
        end else begin
          alt_nxt = 34'(34'(nday_r) * 34'(SECS_DAY)) + off34;
        end
      end
      ST_MONTH3: begin
        deadline_nxt = alt_r[31:0];
      end
      ST_KEY: begin
        idx_nxt = CW'(0);
        if (!cur_en && !ksel_r) begin
          ksel_nxt = 1'b1;
        end
      end
      ST_SRD: begin
      end
      ST_SCMP: begin
        if (key_hit) begin
          slot_nxt = idx_r[IW-1:0];
        end else begin
          idx_nxt = idx_inc;
        end
      end
      ST_MISS: begin
        if (!job_r.is_query) begin
          if (table_full) begin
            dropped_nxt = 1'b1;
          end else begin
            key_we   = 1'b1;
            byte_we  = 1'b1;
            fill_nxt = CW'(fill_r + CW'(1));
            if (ksel_r) begin
              s1_nxt    = 1'b1;
              slot1_nxt = fill_r[IW-1:0];
              v1_nxt    = len64;
            end else begin
              s0_nxt    = 1'b1;
              slot0_nxt = fill_r[IW-1:0];
              v0_nxt    = len64;
            end
          end
          ksel_nxt = 1'b1;
        end
      end
      ST_BRD: begin
      end
      ST_BUPD: begin
        if (job_r.is_query) begin
          found_nxt = 1'b1;
          count_nxt = byte_rd_r;
        end else begin
          byte_we    = 1'b1;
          byte_waddr = slot_r;
          byte_wdata = upd_val;
          ksel_nxt   = 1'b1;
          if (ksel_r) begin
            s1_nxt    = 1'b1;
            slot1_nxt = slot_r;
            v1_nxt    = upd_val;
          end else begin
            s0_nxt    = 1'b1;
            slot0_nxt = slot_r;
            v0_nxt    = upd_val;
          end
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.matched        = matched;
          out_data_nxt.found          = found_r;
          out_data_nxt.byte_count     = count_r;
          out_data_nxt.insert_dropped = dropped_r && !job_r.is_query;
          total_nxt                   = total_eff;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      total_r     <= 64'd0;
      deadline_r  <= 32'd0;
      fill_r      <= CW'(0);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      deadline_r  <= deadline_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r      <= job_nxt;
    idx_r      <= idx_nxt;
    ksel_r     <= ksel_nxt;
    slot_r     <= slot_nxt;
    slot0_r    <= slot0_nxt;
    slot1_r    <= slot1_nxt;
    s0_r       <= s0_nxt;
    s1_r       <= s1_nxt;
    v0_r       <= v0_nxt;
    v1_r       <= v1_nxt;
    dropped_r  <= dropped_nxt;
    found_r    <= found_nxt;
    count_r    <= count_nxt;
    q_r        <= q_nxt;
    base_r     <= base_nxt;
    year_r     <= year_nxt;
    y4_r       <= y4_nxt;
    y100_r     <= y100_nxt;
    y400_r     <= y400_nxt;
    start_r    <= start_nxt;
    alt_r      <= alt_nxt;
    nday_r     <= nday_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_waddr] <= key_wdata;
    end
    key_rd_r <= key_mem[idx_r[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (byte_we) begin
      byte_mem[byte_waddr] <= byte_wdata;
    end
    byte_rd_r <= byte_mem[slot_r];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/per_host_byte_quota_meter.sv @@
// ----------------------------------------------------------------------------
// per_host_byte_quota_meter
// Counts packet bytes per host or in total, clears the counts at calendar
// boundaries, and answers per-host count queries.
//
//   channel | direction | handshake          | word
//   in_     | input     | in_valid/in_stall  | phbqm_in_t
//   out_    | output    | out_valid/out_stall| phbqm_out_t
//   cfg_    | input     | cfg_we             | cfg_index, cfg_wdata
//
// An item passes the period check, a key step per key slot (one for a query,
// two for a packet), then for each key looked up a read and compare of each
// stored entry in turn and an update of a hit or an insert of a miss. A
// stalled output holds the finish. A period reset clears every stored count
// while the reciprocal divider runs, then adds a weekday division for weekly
// periods, and for monthly a year walk from 1970 and a month lookup.
// Reset is synchronous; the host table starts empty, and the configuration, running total and next clear time at zero.
// Two words queue at the input; a stalled output holds the engine in place.
// ----------------------------------------------------------------------------
module per_host_byte_quota_meter #(
  parameter int TABLE_ENTRIES = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  phbqm_pkg::phbqm_in_t in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output phbqm_pkg::phbqm_out_t out_data,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [63:0]          cfg_wdata
);
  import phbqm_pkg::*;

  phbqm_cfg_t cfg_r;
  phbqm_job_t push_data;
  phbqm_job_t pop_data;
  logic       q_push, q_pop, q_full, q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COUNT_MODE:   cfg_r.count_mode   <= cfg_wdata[2:0];
        REG_SUBNET_BASE:  cfg_r.subnet_base  <= cfg_wdata[31:0];
        REG_SUBNET_MASK:  cfg_r.subnet_mask  <= cfg_wdata[31:0];
        REG_BYTE_CUTOFF:  cfg_r.byte_cutoff  <= cfg_wdata;
        REG_COMPARE_MODE: cfg_r.compare_mode <= cfg_wdata[1:0];
        REG_RESET_PERIOD: cfg_r.reset_period <= cfg_wdata[2:0];
        REG_RESET_OFFSET: cfg_r.reset_offset <= cfg_wdata[21:0];
        default: begin
        end
      endcase
    end
  end

  phbqm_front u_front (
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (push_data)
  );

  phbqm_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  phbqm_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_data    (pop_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

`ifndef SYNTHESIS
  a_queue_state: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_full && q_empty))
    else $error("queue reports full and empty together");

  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> !q_empty)
    else $error("accepted word did not reach the queue");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");
`endif

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the per-host byte quota meter. A queue of packet and
// query words feeds a clocked driver, and a clocked monitor compares every
// result with the value computed by an in-bench model of the host table,
// the period clearing and the quota comparison. The run steps through several
// register settings, with random idle and stall cycles on both channels.
// ----------------------------------------------------------------------------
module tb;
  import phbqm_pkg::*;

  localparam int          N_HOSTS    = 256;
  localparam longint      CYCLE_CAP  = 40000000;
  localparam logic        ACT_PACKET = 1'b0;
  localparam int          N_PHASES   = 12;
  localparam int          PHASE_ITEMS = 100;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  phbqm_in_t   in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  phbqm_out_t  out_data;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_wdata = '0;

  per_host_byte_quota_meter dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow registers and host table.
  phbqm_cfg_t      regs = '0;
  logic [31:0]     host_addr [N_HOSTS];
  bit              host_used [N_HOSTS];
  longint unsigned host_count [N_HOSTS];
  longint unsigned sum_bytes = 0;
  logic [31:0]     clear_at = '0;

  phbqm_in_t  pending_words [$];
  phbqm_out_t expected_results [$];
  logic [31:0] addr_pool [32];
  int  fails = 0, n_words = 0, n_queries = 0, n_drops = 0, n_matches = 0;
  int  in_gap = 0, out_hold = 0;
  bit  in_burst = 1'b0, out_burst = 1'b0, wide_addrs = 1'b0;
  longint cycles = 0;
  logic [30:0] clock_now = '0;

  function automatic bit is_leap(int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic longint unsigned month_first(int m, bit lp);
    int unsigned firsts [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
    return firsts[m] + ((lp && m >= 2) ? 1 : 0);
  endfunction

  function automatic longint unsigned after_fixed(longint unsigned now,
      longint unsigned bound, longint unsigned span);
    longint unsigned late;
    if (regs.reset_offset != 0) begin
      late = bound + regs.reset_offset;
      if (late > span && late - span > now) return late - span;
      return late;
    end
    return bound;
  endfunction

  function automatic longint unsigned after_month(longint unsigned now);
    longint unsigned day, start, ylen, yday, alt;
    int unsigned year;
    int m;
    bit done, lp;
    day = now / 86400; start = 0; year = 1970; ylen = 365; done = 0;
    while (!done) begin
      ylen = is_leap(year) ? 366 : 365;
      if (start + ylen > day || year >= 2100) done = 1;
      else begin
        start += ylen;
        year++;
      end
    end
    yday = day - start;
    lp = is_leap(year);
    m = 11;
    while (m > 0 && month_first(m, lp) > yday) m--;
    alt = (start + month_first(m, lp)) * 86400 + regs.reset_offset;
    if (alt > now) return alt;
    if (m == 11) return (start + ylen) * 86400 + regs.reset_offset;
    return (start + month_first(m + 1, lp)) * 86400 + regs.reset_offset;
  endfunction

  function automatic longint unsigned next_clear(longint unsigned now);
    longint unsigned d;
    case (regs.reset_period)
      PER_MINUTE: return after_fixed(now, (now / 60 + 1) * 60, 60);
      PER_HOUR:   return after_fixed(now, (now / 3600 + 1) * 3600, 3600);
      PER_DAY:    return after_fixed(now, (now / 86400 + 1) * 86400, 86400);
      PER_WEEK: begin
        d = now / 86400;
        return after_fixed(now, (d + 7 - (4 + d) % 7) * 86400, 604800);
      end
      PER_MONTH:  return after_month(now);
      default:    return clear_at;
    endcase
  endfunction

  function automatic bit over_quota(longint unsigned v);
    if (regs.compare_mode == CMP_ABOVE) return v > regs.byte_cutoff;
    if (regs.compare_mode == CMP_BELOW) return v < regs.byte_cutoff;
    return 1'b0;
  endfunction

  function automatic int lookup_host(logic [31:0] key);
    for (int i = 0; i < N_HOSTS; i++)
      if (host_used[i] && host_addr[i] == key) return i;
    return -1;
  endfunction

  function automatic int claim_host(logic [31:0] key, inout bit dropped);
    int i;
    i = lookup_host(key);
    if (i >= 0) return i;
    for (int j = 0; j < N_HOSTS; j++)
      if (!host_used[j]) begin
        host_used[j] = 1'b1;
        host_addr[j] = key;
        host_count[j] = 0;
        return j;
      end
    dropped = 1'b1;
    return -1;
  endfunction

  // Applies one accepted word to the model and queues the result it implies.
  function automatic void meter_word(phbqm_in_t w);
    phbqm_out_t r;
    int slot [2];
    logic [31:0] key [2];
    bit dropped, src_in, dst_in, want_in;
    int q;
    r = '0; slot = '{-1, -1}; key = '{32'd0, 32'd0}; dropped = 1'b0;
    if (regs.reset_period >= PER_MINUTE && regs.reset_period <= PER_MONTH &&
        clear_at < w.now_local_seconds) begin
      sum_bytes = 0;
      for (int i = 0; i < N_HOSTS; i++) host_count[i] = 0;
      clear_at = 32'(next_clear(w.now_local_seconds));
    end
    if (w.action == ACT_QUERY) begin
      q = lookup_host(w.query_addr);
      r.found = (q >= 0);
      r.byte_count = (q >= 0) ? host_count[q] : 64'd0;
    end else begin
      if (regs.count_mode == MODE_COMBINED) begin
        slot[0] = claim_host(32'd0, dropped);
        if (slot[0] >= 0) host_count[slot[0]] += w.packet_length;
        sum_bytes += w.packet_length;
      end else if (regs.count_mode <= MODE_REMOTE) begin
        if (regs.count_mode == MODE_SRC) key[0] = w.src_addr;
        else if (regs.count_mode == MODE_DST) key[0] = w.dst_addr;
        else begin
          src_in = (regs.subnet_mask & w.src_addr) == regs.subnet_base;
          dst_in = (regs.subnet_mask & w.dst_addr) == regs.subnet_base;
          want_in = (regs.count_mode == MODE_LOCAL);
          key[0] = (src_in == want_in) ? w.src_addr : 32'd0;
          key[1] = (dst_in == want_in) ? w.dst_addr : 32'd0;
        end
        for (int i = 0; i < 2; i++)
          if (key[i] != 0) begin
            slot[i] = claim_host(key[i], dropped);
            if (slot[i] >= 0) host_count[slot[i]] += w.packet_length;
          end
      end
      r.matched = over_quota(sum_bytes);
      for (int i = 0; i < 2; i++)
        if (slot[i] >= 0 && over_quota(host_count[slot[i]])) r.matched = 1'b1;
      r.insert_dropped = dropped;
    end
    expected_results.push_back(r);
  endfunction

  // Driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        meter_word(in_data);
        n_words++;
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          in_data <= pending_words.pop_front();
          in_valid <= 1'b1;
          in_gap = in_burst ? 0 : $urandom_range(0, 17);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor.
  always @(posedge clk) begin
    phbqm_out_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result word with nothing expected");
          fails++;
        end else begin
          e = expected_results.pop_front();
          if (out_data.matched !== e.matched) begin
            $error("matched: expected %0d, got %0d", e.matched, out_data.matched);
            fails++;
          end
          if (out_data.found !== e.found) begin
            $error("found: expected %0d, got %0d", e.found, out_data.found);
            fails++;
          end
          if (out_data.byte_count !== e.byte_count) begin
            $error("byte_count: expected %0d, got %0d", e.byte_count, out_data.byte_count);
            fails++;
          end
          if (out_data.insert_dropped !== e.insert_dropped) begin
            $error("insert_dropped: expected %0d, got %0d", e.insert_dropped,
                   out_data.insert_dropped);
            fails++;
          end
          n_matches += e.matched;
          n_drops += e.insert_dropped;
        end
        out_hold = out_burst ? 0 : $urandom_range(0, 17);
      end else if (out_hold > 0) begin
        out_hold--;
      end
      out_stall <= (out_hold > 0);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_COUNT_MODE:   regs.count_mode = val[2:0];
      REG_SUBNET_BASE:  regs.subnet_base = val[31:0];
      REG_SUBNET_MASK:  regs.subnet_mask = val[31:0];
      REG_BYTE_CUTOFF:  regs.byte_cutoff = val;
      REG_COMPARE_MODE: regs.compare_mode = val[1:0];
      REG_RESET_PERIOD: regs.reset_period = val[2:0];
      default:          regs.reset_offset = val[21:0];
    endcase
  endtask

  // Checked at the falling edge so that the driver's updates have settled.
  task automatic wait_idle();
    while (pending_words.size() > 0 || in_valid || expected_results.size() > 0)
      @(negedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_addr();
    case ($urandom_range(0, 7))
      0:       return 32'd0;
      1:       return wide_addrs ? 32'($urandom) : addr_pool[$urandom_range(0, 31)];
      default: return addr_pool[$urandom_range(0, 31)];
    endcase
  endfunction

  function automatic phbqm_in_t random_word();
    phbqm_in_t w;
    w.action = ($urandom_range(0, 3) == 0) ? ACT_QUERY : ACT_PACKET;
    case ($urandom_range(0, 19))
      0:       clock_now = 31'($urandom);
      1, 2:    clock_now = clock_now + 31'($urandom_range(0, 5000000));
      default: clock_now = clock_now + 31'($urandom_range(0, 40));
    endcase
    w.now_local_seconds = clock_now;
    w.src_addr = pick_addr();
    w.dst_addr = ($urandom_range(0, 9) == 0) ? w.src_addr : pick_addr();
    case ($urandom_range(0, 9))
      0:       w.packet_length = 16'd0;
      1:       w.packet_length = 16'hFFFF;
      default: w.packet_length = 16'($urandom);
    endcase
    w.query_addr = ($urandom_range(0, 5) == 0) ? 32'($urandom) : pick_addr();
    return w;
  endfunction

  function automatic phbqm_in_t make_word(logic act, logic [30:0] t, logic [31:0] s,
      logic [31:0] d, logic [15:0] len, logic [31:0] qa);
    phbqm_in_t w;
    w.action = act; w.now_local_seconds = t; w.src_addr = s; w.dst_addr = d;
    w.packet_length = len; w.query_addr = qa;
    return w;
  endfunction

  initial begin
    logic [63:0] cut;
    for (int i = 0; i < N_HOSTS; i++) begin
      host_used[i] = 1'b0;
      host_count[i] = 0;
    end
    for (int i = 0; i < 32; i++)
      addr_pool[i] = (i < 16) ? {24'hC0A801, 8'(i + 1)} : 32'($urandom) | 32'd1;
    addr_pool[31] = 32'hFFFFFFFF;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes under reset values, then per-address counting.
    pending_words.push_back(make_word(ACT_QUERY, 31'd0, '0, '0, '0, 32'd0));
    pending_words.push_back(make_word(ACT_PACKET, 31'd0, '0, '0, 16'd0, '0));
    pending_words.push_back(make_word(ACT_PACKET, 31'h7FFFFFFF, '1, '1, 16'hFFFF, '1));
    pending_words.push_back(make_word(ACT_QUERY, 31'h7FFFFFFF, '1, '1, 16'hFFFF, 32'd0));
    pending_words.push_back(make_word(ACT_QUERY, 31'd5, '0, '0, '0, 32'hFFFFFFFF));
    wait_idle();
    write_reg(REG_COUNT_MODE, 64'(MODE_LOCAL));
    write_reg(REG_SUBNET_BASE, 64'hC0A80100);
    write_reg(REG_SUBNET_MASK, 64'hFFFFFF00);
    write_reg(REG_BYTE_CUTOFF, 64'd1000);
    write_reg(REG_COMPARE_MODE, 64'(CMP_ABOVE));
    write_reg(REG_RESET_PERIOD, 64'(PER_MINUTE));
    write_reg(REG_RESET_OFFSET, 64'd0);
    @(posedge clk) cfg_we <= 1'b0;
    // Same local host on both sides grows twice; a remote side gets key zero.
    pending_words.push_back(make_word(ACT_PACKET, 31'd100, 32'hC0A80105, 32'hC0A80105,
                                      16'd600, '0));
    pending_words.push_back(make_word(ACT_PACKET, 31'd101, 32'hC0A80106, 32'h08080808,
                                      16'd10, '0));
    pending_words.push_back(make_word(ACT_QUERY, 31'd102, '0, '0, '0, 32'hC0A80105));
    pending_words.push_back(make_word(ACT_QUERY, 31'd103, '0, '0, '0, 32'h08080808));
    pending_words.push_back(make_word(ACT_QUERY, 31'd200, '0, '0, '0, 32'hC0A80105));
    pending_words.push_back(make_word(ACT_PACKET, 31'd201, 32'h0A000001, 32'd0,
                                      16'd5, '0));
    wait_idle();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      in_burst = (ph % 4 == 1);
      out_burst = (ph % 4 == 2);
      wide_addrs = (ph >= N_PHASES - 3);
      case ($urandom_range(0, 3))
        0:       cut = 64'd0;
        1:       cut = '1;
        default: cut = 64'($urandom_range(0, 400000));
      endcase
      write_reg(REG_COUNT_MODE, (ph < 8) ? 64'(ph) : 64'($urandom_range(0, 4)));
      if ($urandom_range(0, 1)) begin
        write_reg(REG_SUBNET_BASE, 64'hC0A80100);
        write_reg(REG_SUBNET_MASK, 64'hFFFFFF00);
      end else begin
        write_reg(REG_SUBNET_BASE, ($urandom_range(0, 1)) ? 64'd0 : 64'($urandom));
        write_reg(REG_SUBNET_MASK, ($urandom_range(0, 1)) ? 64'hFFFFFFFF : 64'($urandom));
      end
      write_reg(REG_BYTE_CUTOFF, cut);
      write_reg(REG_COMPARE_MODE, 64'($urandom_range(0, 3)));
      write_reg(REG_RESET_PERIOD, (ph < 8) ? 64'(7 - ph) : 64'($urandom_range(0, 7)));
      case ($urandom_range(0, 2))
        0:       write_reg(REG_RESET_OFFSET, 64'd0);
        1:       write_reg(REG_RESET_OFFSET, 64'h3FFFFF);
        default: write_reg(REG_RESET_OFFSET, 64'($urandom_range(0, 2678399)));
      endcase
      @(posedge clk) cfg_we <= 1'b0;
      for (int k = 0; k < PHASE_ITEMS; k++) pending_words.push_back(random_word());
      wait_idle();
    end

    repeat (50) @(posedge clk);
    $display("Metered %0d words (%0d queries) over %0d register settings.",
             n_words, n_queries, N_PHASES + 2);
    $display("Saw %0d quota matches and %0d refused table inserts.", n_matches, n_drops);
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  always @(posedge clk)
    if (rst_n && in_valid && !in_stall && in_data.action == ACT_QUERY) n_queries++;

endmodule
